// ===== hdl/ckvt_pkg.sv =====
package ckvt_pkg;

	// Default sizes
	localparam int CAPACITY_DEF     = 16;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Fixed field widths
	localparam int KEY_W = 32;
	localparam int PL_W  = 64;
	localparam int POS_W = 4;
	localparam int CNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_FIND   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_ERASED    = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FOUND     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [KEY_W-1:0] key;
		logic [PL_W-1:0]         payload;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
		logic [PL_W-1:0]  found_payload;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
	} res_t;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic compare;  // latch key match for a new transfer
		logic shift;    // erase: take neighbor's entry at or above position
		logic append;   // insert: load new entry at the fill slot
	} cell_ctrl_t;

endpackage

// ===== hdl/ckvt_cell.sv =====
module ckvt_cell #(
	parameter int INDEX        = 0,
	parameter int PAYLOAD_BITS = ckvt_pkg::PAYLOAD_BITS_DEF,
	parameter int IDX_W        = 4,
	parameter int CNT_W        = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ckvt_pkg::cell_ctrl_t        ctrl,
	input  logic [ckvt_pkg::KEY_W-1:0]  cmp_key,
	input  logic [ckvt_pkg::KEY_W-1:0]  new_key,
	input  logic [PAYLOAD_BITS-1:0]     new_payload,
	input  logic [CNT_W-1:0]            count,
	input  logic [IDX_W-1:0]            pos,
	input  logic [ckvt_pkg::KEY_W-1:0]  next_key,
	input  logic [PAYLOAD_BITS-1:0]     next_payload,
	output logic [ckvt_pkg::KEY_W-1:0]  key_q,
	output logic [PAYLOAD_BITS-1:0]     payload_q,
	output logic                        match_q
);
	import ckvt_pkg::*;

	logic occupied;
	logic at_fill;
	logic at_or_above;

	// Slot position relative to fill count and erase point
	assign occupied    = CNT_W'(INDEX) < count;
	assign at_fill     = CNT_W'(INDEX) == count;
	assign at_or_above = IDX_W'(INDEX) >= pos;

	// Match flag for the current transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.compare) begin
			match_q <= occupied && (key_q == cmp_key);
		end
	end

	// Entry storage: shift down from neighbor or append
	always_ff @(posedge clk) begin
		if (ctrl.shift && at_or_above) begin
			key_q     <= next_key;
			payload_q <= next_payload;
		end else if (ctrl.append && at_fill) begin
			key_q     <= new_key;
			payload_q <= new_payload;
		end
	end

endmodule

// ===== hdl/compacting_key_value_table_top.sv =====
// Compacting key/value table: up to CAPACITY unique keys with payloads, kept
// packed in insertion order in a row of cells.
// Input channel: command (operation, key, payload) is transferred at a clock
// edge where start is high and busy is low. Operations are insert, erase and
// find; an unused operation code answers not found and changes nothing.
// Output channel: one result per command, presented on result for exactly one
// cycle with done high. The receiver cannot stall, so results are never held.
// In the transfer cycle every cell compares its stored key to the incoming
// one; in the following (busy) cycle the match flags are combined, the result
// is registered and the cells shift down (erase) or load the new entry
// (insert). The result appears the cycle after busy, while the next command
// can already be transferred.
// Reset clears the fill count and control state; entry contents are left as
// they are and only slots below the fill count are ever read.
module compacting_key_value_table_top #(
	parameter int CAPACITY     = ckvt_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = ckvt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ckvt_pkg::cmd_t command,
	output logic           busy,
	output logic           done,
	output ckvt_pkg::res_t result
);
	import ckvt_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);

	logic                    accept;
	logic                    busy_q;
	logic                    done_q;
	res_t                    res_q;
	cmd_t                    cmd_q;
	logic [CW-1:0]           count_q;
	cell_ctrl_t              ctrl;

	logic [KEY_W-1:0]        cell_key   [CAPACITY];
	logic [PAYLOAD_BITS-1:0] cell_pl    [CAPACITY];
	logic [CAPACITY-1:0]     match_vec;

	logic                    hit;
	logic [IDX_W-1:0]        hit_pos;
	logic [PAYLOAD_BITS-1:0] hit_pl;
	logic                    full;
	logic [PAYLOAD_BITS-1:0] new_pl;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;
	assign full   = count_q == CW'(CAPACITY);
	assign new_pl = cmd_q.payload[PAYLOAD_BITS-1:0];

	// Combine match flags from the cells (keys are unique, so at most one hit)
	always_comb begin
		hit_pos = '0;
		hit_pl  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				hit_pos = hit_pos | IDX_W'(i);
				hit_pl  = hit_pl | cell_pl[i];
			end
		end
		hit = |match_vec;
	end

	// Cell control
	always_comb begin
		ctrl.compare = accept;
		ctrl.shift   = busy_q && (cmd_q.operation == OP_ERASE) && hit;
		ctrl.append  = busy_q && (cmd_q.operation == OP_INSERT) && !hit && !full;
	end

	// Row of cells, each fed by its upper neighbor
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_W-1:0]        nb_key;
		logic [PAYLOAD_BITS-1:0] nb_pl;

		if (g == CAPACITY - 1) begin : g_last
			assign nb_key = '0;
			assign nb_pl  = '0;
		end else begin : g_mid
			assign nb_key = cell_key[g+1];
			assign nb_pl  = cell_pl[g+1];
		end

		ckvt_cell #(
			.INDEX        (g),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.IDX_W        (IDX_W),
			.CNT_W        (CW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.cmp_key      (command.key),
			.new_key      (cmd_q.key),
			.new_payload  (new_pl),
			.count        (count_q),
			.pos          (hit_pos),
			.next_key     (nb_key),
			.next_payload (nb_pl),
			.key_q        (cell_key[g]),
			.payload_q    (cell_pl[g]),
			.match_q      (match_vec[g])
		);
	end

	// Command register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
		end
	end

	// Control, fill count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				if (ctrl.append) begin
					count_q <= count_q + CW'(1);
				end else if (ctrl.shift) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		logic [CW-1:0] cnt_next;
		status_t       st;
		logic          report_pos;
		if (busy_q) begin
			cnt_next   = count_q;
			st         = ST_NOT_FOUND;
			report_pos = 1'b0;
			case (cmd_q.operation)
				OP_INSERT: begin
					if (hit) begin
						st         = ST_DUPLICATE;
						report_pos = 1'b1;
					end else if (full) begin
						st = ST_FULL;
					end else begin
						st       = ST_INSERTED;
						cnt_next = count_q + CW'(1);
					end
				end
				OP_ERASE: begin
					if (hit) begin
						st         = ST_ERASED;
						report_pos = 1'b1;
						cnt_next   = count_q - CW'(1);
					end
				end
				OP_FIND: begin
					if (hit) begin
						st         = ST_FOUND;
						report_pos = 1'b1;
					end
				end
				default: begin
					st = ST_NOT_FOUND;
				end
			endcase
			res_q.status        <= st;
			res_q.position      <= report_pos ? POS_W'(hit_pos) : '0;
			res_q.found_payload <= (st == ST_FOUND) ? PL_W'(hit_pl) : '0;
			res_q.entry_count   <= CNT_W'(cnt_next);
			res_q.is_empty      <= cnt_next == '0;
		end
	end

	// Checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a busy cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(match_vec))
		else $error("more than one cell matched the key");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("transfer not followed by a busy cycle");

endmodule
